// ----- rtl/core/fal_pkg.sv -----
// Shared types and codes for the fixed array list.
package fal_pkg;

    localparam int DATA_W    = 32;
    localparam int POS_W     = 5;
    localparam int CNT_OUT_W = 5;

    typedef enum logic [2:0] {
        REQ_INS_HEAD = 3'd0,
        REQ_INS_TAIL = 3'd1,
        REQ_INS_POS  = 3'd2,
        REQ_RM_HEAD  = 3'd3,
        REQ_RM_TAIL  = 3'd4,
        REQ_RM_POS   = 3'd5
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAKE_RD,
        S_TAKE_GET,
        S_CHECK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_FINISH
    } t_state;

endpackage

// ----- rtl/core/fal_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module fal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/core/fixed_array_list.sv -----
// Fixed array list: insert/remove at head, tail or position over one shared RAM.
// Insert: check, then a read, write and check per shifted entry, then put the value and finish.
// Remove: read the entry at the position, then a read, write and check per shifted entry, then finish.
// A rejected item goes straight to finish. The strobe comes in finish; a new item is taken after it.
// Each moved entry costs a read, a write and a check on the single RAM port pair.
// Synchronous reset empties the list; RAM contents are not cleared. No output stall.
module fixed_array_list
    import fal_pkg::*;
#(
    parameter int CAPACITY = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           i_req_type,
    input  logic [POS_W-1:0]     i_position,
    input  logic [DATA_W-1:0]    i_value,
    output logic                 o_strobe,
    output logic [DATA_W-1:0]    o_removed_value,
    output logic [1:0]           o_status,
    output logic [CNT_OUT_W-1:0] o_count_after
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = (CW > POS_W) ? CW : POS_W;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_pos, n_pos;
    logic              r_dir_up, n_dir_up;
    logic [DATA_W-1:0] r_val, n_val;
    logic [DATA_W-1:0] r_removed, n_removed;
    t_status           r_status, n_status;

    logic              w_accept;
    logic              w_is_ins;
    logic              w_is_rm;
    logic [MW-1:0]     w_tpos;
    logic [MW-1:0]     w_count_ext;
    t_status           w_stat;
    logic [CW-1:0]     w_src;
    logic              w_more;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_rdata;

    assign w_accept    = start && (r_state == S_IDLE);
    assign w_count_ext = MW'(r_count);

    // shared index adder: step toward the source entry of the next move
    assign w_src  = r_idx + (r_dir_up ? {CW{1'b1}} : CW'(1));
    assign w_more = r_dir_up ? (r_idx > r_pos) : (w_src < r_count);

    // request decode and checks
    always_comb begin
        w_is_ins = 1'b0;
        w_is_rm  = 1'b0;
        w_tpos   = '0;
        case (t_req'(i_req_type))
            REQ_INS_HEAD: begin
                w_is_ins = 1'b1;
            end
            REQ_INS_TAIL: begin
                w_is_ins = 1'b1;
                w_tpos   = w_count_ext;
            end
            REQ_INS_POS: begin
                w_is_ins = 1'b1;
                w_tpos   = MW'(i_position);
            end
            REQ_RM_HEAD: begin
                w_is_rm = 1'b1;
            end
            REQ_RM_TAIL: begin
                w_is_rm = 1'b1;
                w_tpos  = w_count_ext - MW'(1);
            end
            REQ_RM_POS: begin
                w_is_rm = 1'b1;
                w_tpos  = MW'(i_position);
            end
            default: begin
                w_tpos = '0;
            end
        endcase

        if (w_is_ins) begin
            if (r_count == CW'(CAPACITY)) begin
                w_stat = ST_FULL;
            end else if (w_tpos > w_count_ext) begin
                w_stat = ST_RANGE;
            end else begin
                w_stat = ST_OK;
            end
        end else if (w_is_rm) begin
            if (r_count == '0) begin
                w_stat = ST_EMPTY;
            end else if (w_tpos >= w_count_ext) begin
                w_stat = ST_RANGE;
            end else begin
                w_stat = ST_OK;
            end
        end else begin
            w_stat = ST_RANGE;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (w_stat != ST_OK) begin
                        n_state = S_FINISH;
                    end else if (w_is_ins) begin
                        n_state = S_CHECK;
                    end else begin
                        n_state = S_TAKE_RD;
                    end
                end
            end
            S_TAKE_RD:  n_state = S_TAKE_GET;
            S_TAKE_GET: n_state = S_CHECK;
            S_CHECK: begin
                if (w_more) begin
                    n_state = S_SHIFT_RD;
                end else if (r_dir_up) begin
                    n_state = S_PUT;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: n_state = S_CHECK;
            S_PUT:      n_state = S_FINISH;
            S_FINISH:   n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and RAM control
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_pos     = r_pos;
        n_dir_up  = r_dir_up;
        n_val     = r_val;
        n_removed = r_removed;
        n_status  = r_status;
        w_we      = 1'b0;
        w_waddr   = r_idx[AW-1:0];
        w_wdata   = w_rdata;
        w_raddr   = w_src[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_status  = w_stat;
                    n_removed = '0;
                    n_val     = i_value;
                    n_dir_up  = w_is_ins;
                    n_pos     = CW'(w_tpos);
                    n_idx     = w_is_ins ? r_count : CW'(w_tpos);
                end
            end
            S_TAKE_RD: begin
                w_raddr = r_pos[AW-1:0];
            end
            S_TAKE_GET: begin
                n_removed = w_rdata;
            end
            S_CHECK: begin
                if (!w_more && !r_dir_up) begin
                    n_count = r_count - CW'(1);
                end
            end
            S_SHIFT_RD: begin
                w_raddr = w_src[AW-1:0];
            end
            S_SHIFT_WR: begin
                w_we  = 1'b1;
                n_idx = w_src;
            end
            S_PUT: begin
                w_we    = 1'b1;
                w_waddr = r_pos[AW-1:0];
                w_wdata = r_val;
                n_count = r_count + CW'(1);
            end
            S_FINISH: begin
                n_count = r_count;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_idx     <= n_idx;
        r_pos     <= n_pos;
        r_dir_up  <= n_dir_up;
        r_val     <= n_val;
        r_removed <= n_removed;
        r_status  <= n_status;
    end

    fal_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    logic [MW-1:0] w_count_out;
    assign w_count_out     = MW'(r_count);

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = (r_state == S_FINISH);
    assign o_removed_value = r_removed;
    assign o_status        = r_status;
    assign o_count_after   = w_count_out[CNT_OUT_W-1:0];

    // an accepted item always raises busy in the cycle after it is taken
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("accepted item did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe held longer than one cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count above capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_status == ST_FULL) |-> (r_count == CW'(CAPACITY)))
        else $error("full status with room left");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_SHIFT_WR || r_state == S_PUT))
        else $error("RAM written outside a move or put step");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the fixed array list: random and directed requests.
module tb_top;
    import fal_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CAP = 16;
    localparam int DRAIN_CYCLES = 60;
    // request codes the block has no name for; both must be rejected
    localparam logic [2:0] REQ_BOGUS_LO = 3'd6;
    localparam logic [2:0] REQ_BOGUS_HI = 3'd7;

    typedef struct packed {
        logic [2:0]        req;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] val;
    } req_item_t;

    typedef struct packed {
        logic [DATA_W-1:0]    removed;
        t_status              status;
        logic [CNT_OUT_W-1:0] count;
    } outcome_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [2:0]           i_req_type = '0;
    logic [POS_W-1:0]     i_position = '0;
    logic [DATA_W-1:0]    i_value = '0;
    logic                 o_strobe;
    logic [DATA_W-1:0]    o_removed_value;
    logic [1:0]           o_status;
    logic [CNT_OUT_W-1:0] o_count_after;

    req_item_t   pending_q[$];
    outcome_t    outcome_q[$];
    logic [31:0] list_vals[CAP];
    int          list_len = 0;
    int          fails = 0;
    int          fill = 0;       // occupancy as the stimulus generator sees it
    int          idle_left = 0;
    bit          no_idle = 1'b0;
    bit          took_item = 1'b0;

    fixed_array_list #(.CAPACITY(CAP)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_req_type      (i_req_type),
        .i_position      (i_position),
        .i_value         (i_value),
        .o_strobe        (o_strobe),
        .o_removed_value (o_removed_value),
        .o_status        (o_status),
        .o_count_after   (o_count_after)
    );

    always #5 i_clk = ~i_clk;

    // Applies one request to the shadow list and returns what the block should report.
    function automatic outcome_t apply_request(logic [2:0] req, logic [POS_W-1:0] pos,
                                               logic [DATA_W-1:0] val);
        outcome_t o;
        int at;
        int k;
        o.removed = '0;
        o.status = ST_OK;
        case (req)
            REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS: begin
                at = (req == REQ_INS_HEAD) ? 0 : (req == REQ_INS_TAIL) ? list_len : int'(pos);
                if (list_len >= CAP) begin
                    o.status = ST_FULL;
                end else if (at > list_len) begin
                    o.status = ST_RANGE;
                end else begin
                    for (k = list_len; k > at; k--)
                        list_vals[k] = list_vals[k-1];
                    list_vals[at] = val;
                    list_len++;
                end
            end
            REQ_RM_HEAD, REQ_RM_TAIL, REQ_RM_POS: begin
                at = (req == REQ_RM_HEAD) ? 0 : (req == REQ_RM_TAIL) ? list_len - 1 : int'(pos);
                if (list_len == 0) begin
                    o.status = ST_EMPTY;
                end else if (at >= list_len) begin
                    o.status = ST_RANGE;
                end else begin
                    o.removed = list_vals[at];
                    for (k = at; k + 1 < list_len; k++)
                        list_vals[k] = list_vals[k+1];
                    list_len--;
                end
            end
            default: o.status = ST_RANGE;
        endcase
        o.count = list_len[CNT_OUT_W-1:0];
        return o;
    endfunction

    // Queues a request and tracks the list occupancy it leads to.
    task automatic add_req(logic [2:0] req, int pos, logic [DATA_W-1:0] val);
        req_item_t it;
        it.req = req;
        it.pos = pos[POS_W-1:0];
        it.val = val;
        pending_q.push_back(it);
        if (req inside {REQ_INS_HEAD, REQ_INS_TAIL, REQ_INS_POS}) begin
            if (fill < CAP && (req != REQ_INS_POS || pos <= fill))
                fill++;
        end else if (req inside {REQ_RM_HEAD, REQ_RM_TAIL, REQ_RM_POS}) begin
            if (fill > 0 && (req != REQ_RM_POS || pos < fill))
                fill--;
        end
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return '0;
            default: return $urandom;
        endcase
    endfunction

    // Driver: presents the next item at the falling edge, holds it until taken.
    always @(negedge i_clk) begin
        req_item_t it;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || took_item) begin
            if (start) begin
                if ($urandom_range(0, 31) == 0)
                    no_idle = !no_idle;
                idle_left = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (idle_left > 0) begin
                idle_left--;
                start <= 1'b0;
            end else if (pending_q.size() != 0) begin
                it = pending_q.pop_front();
                i_req_type <= it.req;
                i_position <= it.pos;
                i_value <= it.val;
                start <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: checks results against the oldest expectation, predicts on accept.
    always @(posedge i_clk) begin
        outcome_t want;
        took_item <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (outcome_q.size() == 0) begin
                    $error("result with no request outstanding");
                    fails++;
                end else begin
                    want = outcome_q.pop_front();
                    if (o_removed_value !== want.removed) begin
                        $error("removed_value: expected %h, got %h", want.removed,
                               o_removed_value);
                        fails++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, o_status);
                        fails++;
                    end
                    if (o_count_after !== want.count) begin
                        $error("count_after: expected %0d, got %0d", want.count,
                               o_count_after);
                        fails++;
                    end
                end
            end
            if (start && !busy)
                outcome_q.push_back(apply_request(i_req_type, i_position, i_value));
        end
    end

    initial begin
        int n;
        int phase;
        int phase_left;
        int p;
        int hi;
        logic [2:0] r;
        bit grow;

        // empty list: removals and a bad insert position
        add_req(REQ_RM_HEAD, 0, '0);
        add_req(REQ_RM_TAIL, 0, '0);
        add_req(REQ_RM_POS, 0, '0);
        add_req(REQ_INS_POS, 1, 32'h1234_5678);
        add_req(REQ_BOGUS_LO, 0, 32'hffff_ffff);
        add_req(REQ_INS_HEAD, 0, 32'h8000_0000);
        add_req(REQ_INS_TAIL, 0, 32'h7fff_ffff);
        add_req(REQ_INS_POS, 2, 32'hffff_ffff);   // position equal to count appends
        add_req(REQ_INS_POS, 0, '0);
        add_req(REQ_INS_POS, 9, 32'h5555_aaaa);
        add_req(REQ_BOGUS_HI, 31, 32'haaaa_5555);
        add_req(REQ_RM_POS, 4, '0);
        while (fill < CAP)
            add_req(REQ_INS_POS, $urandom_range(0, fill), $urandom);
        // full list: full is reported ahead of a bad position
        add_req(REQ_INS_TAIL, 0, $urandom);
        add_req(REQ_INS_POS, 31, $urandom);
        add_req(REQ_RM_POS, 31, '0);
        add_req(REQ_RM_POS, CAP - 1, '0);
        add_req(REQ_RM_TAIL, 0, '0);
        add_req(REQ_RM_HEAD, 0, '0);

        // random phases: growing, shrinking, or raw noise
        phase = 0;
        phase_left = 0;
        for (n = 0; n < 800; n++) begin
            if (phase_left == 0) begin
                phase = $urandom_range(0, 4);
                phase_left = $urandom_range(20, 60);
            end
            phase_left--;
            if (phase == 4) begin
                r = $urandom_range(0, 7);
                p = $urandom_range(0, 31);
            end else begin
                grow = (phase < 2) ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) < 3);
                r = grow ? $urandom_range(0, 2) : $urandom_range(3, 5);
                hi = grow ? fill : ((fill > 0) ? fill - 1 : 0);
                p = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 31) : $urandom_range(0, hi);
            end
            add_req(r, p, pick_value());
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || start || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0 && outcome_q.size() == 0) begin
            $display("fixed_array_list test passed");
        end else begin
            $display("fixed_array_list test failed");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("fixed_array_list test failed");
        $finish;
    end

endmodule
